/* hdl/tscd_pkg.sv */
// Shared constants, types and state codes of the tanh soft-clip distortion block.
package tscd_pkg;

   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int TANH_SEGMENTS_DEF = 64;

   localparam int DRIVE_W     = 16;
   localparam int DRIVE_FRAC  = 12;
   localparam int MIX_W       = 16;
   localparam int MIX_FRAC    = 15;
   localparam int POST_DB_W   = 12;
   localparam int POST_MAG_W  = 11;
   localparam int POST_Y_W    = 32;
   localparam int POST_FRAC   = 30;
   localparam int POST_MULT_W = 31;
   localparam int WEIGHT_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int EXP_TERMS   = 24;
   localparam int EXP_MAX_INT = 40;

   localparam logic [DRIVE_W-1:0]     DRIVE_RESET        = 16'd4096;
   localparam logic [MIX_W-1:0]       MIX_ONE            = 16'd32768;
   localparam logic [POST_MULT_W-1:0] ONE_Q30            = 31'h4000_0000;
   localparam logic [28:0]            INV_E_Q30          = 29'd395007542;
   localparam logic [20:0]            LN10_CENTI_DB_Q30  = 21'd1236191;
   localparam logic [POST_MAG_W-1:0]  POST_MAG_MAX       = 11'd1200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_GAIN = 2'd0,
      CSR_WET_MIX    = 2'd1,
      CSR_POST_GAIN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic channel;
   } tscd_tag_type;

   typedef enum logic [2:0] {
      PG_IDLE,
      PG_LOAD,
      PG_MUL,
      PG_DIV,
      PG_ACC,
      PG_CLAMP,
      PG_EXP,
      PG_DONE
   } pg_state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic mul;
      logic div_step;
      logic acc_step;
      logic clamp;
      logic exp_step;
      logic commit;
   } pg_ctrl_type;

endpackage

/* hdl/tscd_post_gain.sv */
// Serial unit that turns the post gain in centi-dB into a linear Q1.30 multiplier.
module tscd_post_gain import tscd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [POST_DB_W-1:0] gain_db,
   output logic                        busy,
   output logic [POST_MULT_W-1:0]      post_mult
);

   localparam int ACC_W     = POST_MULT_W + 2;
   localparam int TERM_W    = $clog2(EXP_TERMS + 1);
   localparam int RCP_W     = POST_FRAC + 1;
   localparam int RSH_W     = $clog2(POST_FRAC + $clog2(EXP_TERMS) + 1);
   localparam int N_W       = POST_Y_W - POST_FRAC;

   typedef logic [RCP_W-1:0] rcp_tab_type [EXP_TERMS+1];
   typedef logic [RSH_W-1:0] rsh_tab_type [EXP_TERMS+1];

   function automatic rcp_tab_type build_rcp();
      rcp_tab_type t;
      logic [63:0] num;
      int          k;
      t[0] = '0;
      for (k = 1; k <= EXP_TERMS; k++) begin
         num  = 64'd1 << (POST_FRAC + $clog2(k));
         t[k] = RCP_W'((num + 64'(k) - 64'd1) / 64'(k));
      end
      return t;
   endfunction

   function automatic rsh_tab_type build_rsh();
      rsh_tab_type t;
      int          k;
      t[0] = '0;
      for (k = 1; k <= EXP_TERMS; k++) begin
         t[k] = RSH_W'(POST_FRAC + $clog2(k));
      end
      return t;
   endfunction

   localparam rcp_tab_type RCP_TAB = build_rcp();
   localparam rsh_tab_type RSH_TAB = build_rsh();

   pg_state_type              state_ff, state_in;
   pg_ctrl_type               ctrl;
   logic [POST_MAG_W-1:0]     dmag_ff, dmag_in;
   logic [N_W-1:0]            n_ff;
   logic [POST_FRAC-1:0]      f_ff;
   logic [POST_MULT_W-1:0]    quo_ff;
   logic [TERM_W-1:0]         i_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [POST_MULT_W-1:0]    r_ff;
   logic [POST_MULT_W-1:0]    post_mult_ff;

   logic [POST_Y_W-1:0]                 y_full;
   logic [POST_MULT_W+POST_FRAC-1:0]    term_prod;
   logic [POST_FRAC+RCP_W-1:0]          rcp_prod;
   logic [POST_FRAC+RCP_W-1:0]          rcp_quo;
   logic [POST_MULT_W+29:0]             exp_prod;
   logic signed [ACC_W-1:0]             term_ext;

   always_comb begin
      if (gain_db > 0) begin
         dmag_in = '0;
      end else if (gain_db < -$signed({1'b0, POST_MAG_MAX})) begin
         dmag_in = POST_MAG_MAX;
      end else begin
         dmag_in = POST_MAG_W'(-gain_db);
      end
   end

   always_comb begin
      state_in = state_ff;
      if (start) begin
         state_in = PG_LOAD;
      end else begin
         unique case (state_ff)
            PG_IDLE:  state_in = PG_IDLE;
            PG_LOAD:  state_in = PG_MUL;
            PG_MUL:   state_in = PG_DIV;
            PG_DIV:   state_in = PG_ACC;
            PG_ACC:   state_in = (i_ff == TERM_W'(EXP_TERMS)) ? PG_CLAMP : PG_MUL;
            PG_CLAMP: state_in = (n_ff == '0) ? PG_DONE : PG_EXP;
            PG_EXP:   if (n_ff == N_W'(1)) state_in = PG_DONE;
            PG_DONE:  state_in = PG_IDLE;
            default:  state_in = PG_IDLE;
         endcase
      end
   end

   always_comb begin
      ctrl = '0;
      ctrl.capture = start;
      unique case (state_ff)
         PG_IDLE:  ;
         PG_LOAD:  ctrl.load     = 1'b1;
         PG_MUL:   ctrl.mul      = 1'b1;
         PG_DIV:   ctrl.div_step = 1'b1;
         PG_ACC:   ctrl.acc_step = 1'b1;
         PG_CLAMP: ctrl.clamp    = 1'b1;
         PG_EXP:   ctrl.exp_step = 1'b1;
         PG_DONE:  ctrl.commit   = 1'b1;
         default:  ;
      endcase
   end

   assign y_full    = POST_Y_W'(dmag_ff) * POST_Y_W'(LN10_CENTI_DB_Q30);
   assign term_prod = quo_ff * f_ff;
   assign rcp_prod  = quo_ff[POST_FRAC-1:0] * RCP_TAB[i_ff];
   assign rcp_quo   = rcp_prod >> RSH_TAB[i_ff];
   assign exp_prod  = r_ff * INV_E_Q30 + ((POST_MULT_W+30)'(1) << (POST_FRAC - 1));
   assign term_ext  = $signed({2'b00, quo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PG_IDLE;
         post_mult_ff <= ONE_Q30;
      end else begin
         state_ff <= state_in;
         if (ctrl.commit) begin
            post_mult_ff <= r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         dmag_ff <= dmag_in;
      end
      if (ctrl.load) begin
         n_ff   <= y_full[POST_Y_W-1:POST_FRAC];
         f_ff   <= y_full[POST_FRAC-1:0];
         quo_ff <= ONE_Q30;
         acc_ff <= $signed({2'b00, ONE_Q30});
         i_ff   <= TERM_W'(1);
      end
      if (ctrl.mul) begin
         quo_ff <= term_prod[POST_FRAC +: POST_MULT_W];
      end
      if (ctrl.div_step) begin
         quo_ff <= rcp_quo[POST_MULT_W-1:0];
      end
      if (ctrl.acc_step) begin
         acc_ff <= i_ff[0] ? acc_ff - term_ext : acc_ff + term_ext;
         i_ff   <= i_ff + TERM_W'(1);
      end
      if (ctrl.clamp) begin
         r_ff <= acc_ff[ACC_W-1] ? '0 : acc_ff[POST_MULT_W-1:0];
      end
      if (ctrl.exp_step) begin
         r_ff <= exp_prod[POST_FRAC +: POST_MULT_W];
         n_ff <= n_ff - N_W'(1);
      end
   end

   assign busy      = state_ff != PG_IDLE;
   assign post_mult = post_mult_ff;

   a_mult_bound: assert property (@(posedge clock) disable iff (reset)
      post_mult_ff <= ONE_Q30)
      else $error("post multiplier above unity");

   a_mult_commit: assert property (@(posedge clock) disable iff (reset)
      (!$stable(post_mult_ff) && !$past(reset)) |-> $past(state_ff == PG_DONE))
      else $error("post multiplier changed outside commit");

endmodule

/* hdl/tscd_shaper.sv */
// Drive multiply and piecewise-linear tanh soft clip, five pipeline stages.
module tscd_shaper import tscd_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  tscd_tag_type                  tag_in,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic [DRIVE_W-1:0]            drive_gain,
   output tscd_tag_type                  tag_out,
   output logic signed [SAMPLE_BITS-1:0] dry_out,
   output logic signed [SAMPLE_BITS:0]   wet_out
);

   localparam int SB  = SAMPLE_BITS;
   localparam int UW  = SB + DRIVE_W;
   localparam int FB3 = SB - 1 + DRIVE_FRAC + 3;
   localparam int IW  = $clog2(TANH_SEGMENTS);
   localparam int PW  = FB3 + IW;

   localparam logic [63:0]         ONE64   = 64'(ONE_Q30);
   localparam logic [SB-1:0]       T_ONE   = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB:0]  WET_MAX = {2'b01, {(SB-1){1'b0}}};

   typedef logic [SB-1:0] ent_type;
   typedef ent_type       seg_tab_type [TANH_SEGMENTS];
   typedef logic [63:0]   full_tab_type [TANH_SEGMENTS+1];

   function automatic logic [63:0] div_small(input logic [63:0] v, input int i);
      logic [63:0] q;
      unique case (i)
         1:  q = v;
         2:  q = v / 2;
         3:  q = v / 3;
         4:  q = v / 4;
         5:  q = v / 5;
         6:  q = v / 6;
         7:  q = v / 7;
         8:  q = v / 8;
         9:  q = v / 9;
         10: q = v / 10;
         11: q = v / 11;
         12: q = v / 12;
         13: q = v / 13;
         14: q = v / 14;
         15: q = v / 15;
         16: q = v / 16;
         17: q = v / 17;
         18: q = v / 18;
         19: q = v / 19;
         20: q = v / 20;
         21: q = v / 21;
         22: q = v / 22;
         23: q = v / 23;
         24: q = v / 24;
         default: q = v;
      endcase
      return q;
   endfunction

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] q;
      int          b;
      rem = '0;
      q   = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
      logic [63:0]        n;
      logic [63:0]        f;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] acc;
      int                 i;
      n    = y >> POST_FRAC;
      f    = y & (ONE64 - 64'd1);
      term = ONE64;
      acc  = $signed(ONE64);
      for (i = 1; i <= EXP_TERMS; i++) begin
         term = div_small((term * f) >> POST_FRAC, i);
         if ((i & 1) != 0) acc = acc - $signed(term);
         else              acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      r = acc;
      if (n > 64'(EXP_MAX_INT)) begin
         r = '0;
      end else begin
         for (i = 0; i < int'(n); i++) begin
            r = (r * 64'(INV_E_Q30) + (ONE64 >> 1)) >> POST_FRAC;
         end
      end
      return r;
   endfunction

   function automatic full_tab_type build_full();
      full_tab_type t;
      logic [63:0]  e;
      logic [63:0]  num;
      logic [63:0]  den;
      int           k;
      for (k = 0; k <= TANH_SEGMENTS; k++) begin
         e = exp_neg_q30((64'(k) << (POST_FRAC + 4)) / TANH_SEGMENTS);
         if (e > ONE64) e = ONE64;
         num  = ONE64 - e;
         den  = ONE64 + e;
         t[k] = udiv64((num << (SB - 1)) + (den >> 1), den);
         if (k > 0 && t[k] < t[k-1]) t[k] = t[k-1];
      end
      return t;
   endfunction

   function automatic seg_tab_type pick_base(input full_tab_type t);
      seg_tab_type b;
      int          k;
      for (k = 0; k < TANH_SEGMENTS; k++) b[k] = t[k][SB-1:0];
      return b;
   endfunction

   function automatic seg_tab_type pick_diff(input full_tab_type t);
      seg_tab_type d;
      int          k;
      for (k = 0; k < TANH_SEGMENTS; k++) d[k] = SB'(t[k+1] - t[k]);
      return d;
   endfunction

   localparam full_tab_type FULL_TAB = build_full();
   localparam seg_tab_type  BASE_TAB = pick_base(FULL_TAB);
   localparam seg_tab_type  DIFF_TAB = pick_diff(FULL_TAB);

   tscd_tag_type          tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic signed [SB-1:0]  x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   logic signed [UW-1:0]  u1_ff, u1_in;
   logic                  neg2_ff, neg3_ff, neg4_ff;
   logic                  sat2_ff, sat3_ff, sat4_ff;
   logic [IW-1:0]         idx2_ff, idx2_in;
   logic [WEIGHT_W-1:0]   w2_ff, w2_in, w3_ff;
   logic [SB-1:0]         base3_ff, base4_ff, diff3_ff;
   logic [SB-1:0]         step4_ff, step4_in;
   logic signed [SB:0]    wet5_ff, wet5_in;

   logic signed [UW:0]    u_full;
   logic [UW-1:0]         mag;
   logic [PW-1:0]         pos;
   logic [SB+WEIGHT_W-1:0] step_prod;
   logic [SB-1:0]         t_mag;

   assign u_full = sample_in * $signed({1'b0, drive_gain});
   assign u1_in  = u_full[UW-1:0];

   assign mag     = u1_ff[UW-1] ? UW'(-u1_ff) : UW'(u1_ff);
   assign pos     = {{IW{1'b0}}, mag[FB3-1:0]} * PW'(TANH_SEGMENTS);
   assign idx2_in = pos[PW-1:FB3];
   assign w2_in   = pos[FB3-1 -: WEIGHT_W];

   assign step_prod = diff3_ff * w3_ff;
   assign step4_in  = step_prod[SB+WEIGHT_W-1:WEIGHT_W];

   assign t_mag   = sat4_ff ? T_ONE : base4_ff + step4_ff;
   assign wet5_in = neg4_ff ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else if (en) begin
         tag1_ff.valid <= tag_in.valid;
         tag2_ff.valid <= tag1_ff.valid;
         tag3_ff.valid <= tag2_ff.valid;
         tag4_ff.valid <= tag3_ff.valid;
         tag5_ff.valid <= tag4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag1_ff.channel <= tag_in.channel;
         x1_ff           <= sample_in;
         u1_ff           <= u1_in;

         tag2_ff.channel <= tag1_ff.channel;
         x2_ff           <= x1_ff;
         neg2_ff         <= u1_ff[UW-1];
         sat2_ff         <= |mag[UW-1:FB3];
         idx2_ff         <= idx2_in;
         w2_ff           <= w2_in;

         tag3_ff.channel <= tag2_ff.channel;
         x3_ff           <= x2_ff;
         neg3_ff         <= neg2_ff;
         sat3_ff         <= sat2_ff;
         base3_ff        <= BASE_TAB[idx2_ff];
         diff3_ff        <= DIFF_TAB[idx2_ff];
         w3_ff           <= w2_ff;

         tag4_ff.channel <= tag3_ff.channel;
         x4_ff           <= x3_ff;
         neg4_ff         <= neg3_ff;
         sat4_ff         <= sat3_ff;
         base4_ff        <= base3_ff;
         step4_ff        <= step4_in;

         tag5_ff.channel <= tag4_ff.channel;
         x5_ff           <= x4_ff;
         wet5_ff         <= wet5_in;
      end
   end

   assign tag_out = tag5_ff;
   assign dry_out = x5_ff;
   assign wet_out = wet5_ff;

   a_wet_range: assert property (@(posedge clock) disable iff (reset)
      tag5_ff.valid |-> (wet5_ff <= WET_MAX && wet5_ff >= -WET_MAX))
      else $error("wet value beyond full scale");

endmodule

/* hdl/tscd_mix.sv */
// Dry/wet mix, post gain scaling and output saturation, four pipeline stages.
module tscd_mix import tscd_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  tscd_tag_type                  tag_in,
   input  logic signed [SAMPLE_BITS-1:0] dry_in,
   input  logic signed [SAMPLE_BITS:0]   wet_in,
   input  logic [MIX_W-1:0]              mix_weight,
   input  logic [POST_MULT_W-1:0]        post_mult,
   output tscd_tag_type                  tag_out,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam int SB  = SAMPLE_BITS;
   localparam int PWW = SB + 1 + MIX_W + 1;
   localparam int PDW = SB + MIX_W + 1;
   localparam int SW  = PWW + 1;
   localparam int VPW = SB + 1 + POST_MULT_W + 1;
   localparam int VW  = VPW - POST_FRAC;

   localparam logic signed [VW-1:0] V_HI = {{(VW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [VW-1:0] V_LO = {{(VW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   tscd_tag_type           tag6_ff, tag7_ff, tag8_ff, tag9_ff;
   logic signed [PWW-1:0]  pw6_ff, pw6_in;
   logic signed [PDW-1:0]  pd6_ff, pd6_in;
   logic signed [SB:0]     s7_ff, s7_in;
   logic signed [VPW-1:0]  vp8_ff, vp8_in;
   logic signed [SB-1:0]   out9_ff, out9_in;

   logic [MIX_W-1:0]       dry_weight;
   logic signed [SW-1:0]   sum_r;
   logic signed [VPW-1:0]  vp_r;
   logic signed [VW-1:0]   vv;

   assign dry_weight = MIX_ONE - mix_weight;
   assign pw6_in     = wet_in * $signed({1'b0, mix_weight});
   assign pd6_in     = dry_in * $signed({1'b0, dry_weight});

   assign sum_r = SW'(pw6_ff) + SW'(pd6_ff) + (SW'(1) <<< (MIX_FRAC - 1));
   assign s7_in = sum_r[MIX_FRAC +: SB+1];

   assign vp8_in = s7_ff * $signed({1'b0, post_mult});

   assign vp_r = vp8_ff + (VPW'(1) <<< (POST_FRAC - 1));
   assign vv   = vp_r[POST_FRAC +: VW];

   always_comb begin
      priority if (vv > V_HI) begin
         out9_in = V_HI[SB-1:0];
      end else if (vv < V_LO) begin
         out9_in = V_LO[SB-1:0];
      end else begin
         out9_in = vv[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag6_ff.valid <= 1'b0;
         tag7_ff.valid <= 1'b0;
         tag8_ff.valid <= 1'b0;
         tag9_ff.valid <= 1'b0;
      end else if (en) begin
         tag6_ff.valid <= tag_in.valid;
         tag7_ff.valid <= tag6_ff.valid;
         tag8_ff.valid <= tag7_ff.valid;
         tag9_ff.valid <= tag8_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag6_ff.channel <= tag_in.channel;
         pw6_ff          <= pw6_in;
         pd6_ff          <= pd6_in;
         tag7_ff.channel <= tag6_ff.channel;
         s7_ff           <= s7_in;
         tag8_ff.channel <= tag7_ff.channel;
         vp8_ff          <= vp8_in;
         tag9_ff.channel <= tag8_ff.channel;
         out9_ff         <= out9_in;
      end
   end

   assign tag_out    = tag9_ff;
   assign sample_out = out9_ff;

endmodule

/* hdl/tanh_soft_clip_distortion_top.sv */
// Top level of the tanh soft-clip distortion block: registers, pipeline and handshake.
//
// Takes one sample per clock while the response side does not stall and no post gain
// derivation is busy, and returns each result in request order; a stalled response
// holds the whole nine-stage pipeline in place. Writing the post gain register starts
// a serial derivation of the linear multiplier (24 series terms, each a multiply,
// divide and accumulate step, and a new post gain write restarts it); req_ready stays
// low until it finishes. Drive gain and wet mix take effect at once.
module tanh_soft_clip_distortion_top import tscd_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int TANH_SEGMENTS = TANH_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_channel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_channel_out,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic [DRIVE_W-1:0]                drive_gain_ff;
   logic [MIX_W-1:0]                  wet_mix_ff;
   logic                              pg_start;
   logic                              pg_busy;
   logic [POST_MULT_W-1:0]            post_mult;
   logic                              en;
   tscd_tag_type                      req_tag;
   tscd_tag_type                      mid_tag;
   tscd_tag_type                      rsp_tag;
   logic signed [SAMPLE_BITS-1:0]     mid_dry;
   logic signed [SAMPLE_BITS:0]       mid_wet;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !pg_busy;
   assign pg_start  = csr_we && (csr_index_type'(csr_index) == CSR_POST_GAIN);

   always_comb begin
      req_tag.valid   = req_valid && req_ready;
      req_tag.channel = req_channel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_gain_ff <= DRIVE_RESET;
         wet_mix_ff    <= MIX_ONE;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRIVE_GAIN: drive_gain_ff <= csr_wdata;
            CSR_WET_MIX:    wet_mix_ff    <= (csr_wdata > MIX_ONE) ? MIX_ONE : csr_wdata;
            default:        ;
         endcase
      end
   end

   tscd_post_gain u_post_gain (
      .clock     (clock),
      .reset     (reset),
      .start     (pg_start),
      .gain_db   ($signed(csr_wdata[POST_DB_W-1:0])),
      .busy      (pg_busy),
      .post_mult (post_mult)
   );

   tscd_shaper #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .TANH_SEGMENTS (TANH_SEGMENTS)
   ) u_shaper (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .tag_in     (req_tag),
      .sample_in  (req_sample_in),
      .drive_gain (drive_gain_ff),
      .tag_out    (mid_tag),
      .dry_out    (mid_dry),
      .wet_out    (mid_wet)
   );

   tscd_mix #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .tag_in     (mid_tag),
      .dry_in     (mid_dry),
      .wet_in     (mid_wet),
      .mix_weight (wet_mix_ff),
      .post_mult  (post_mult),
      .tag_out    (rsp_tag),
      .sample_out (rsp_sample_out)
   );

   assign rsp_valid       = rsp_tag.valid;
   assign rsp_channel_out = rsp_tag.channel;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      pg_busy |-> !req_ready)
      else $error("request accepted while post gain is being derived");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (pg_start && !pg_busy) |=> pg_busy)
      else $error("post gain write did not start derivation");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the tanh soft-clip distortion block.
module testbench import tscd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = SAMPLE_BITS_DEF;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic signed [SB-1:0] sample;
      logic                 channel;
   } audio_item_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [SB-1:0] req_sample_in = '0;
   logic                 req_channel_in = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_sample_out;
   logic                 rsp_channel_out;
   logic                 csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   audio_item_type samples_to_send[$];
   audio_item_type outputs_due[$];

   longint unsigned tanh_knee[0:TANH_SEGMENTS_DEF];
   int unsigned     drive_now = 32'(DRIVE_RESET);
   int unsigned     mix_now = 32'(MIX_ONE);
   longint          post_scale_now = longint'(ONE_Q30);

   int      errors = 0;
   int      requests_accepted = 0;
   bit      req_taken = 1'b0;
   int      burst_left = 1;
   int      gap_left = 0;
   bit      hold_off = 1'b0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int      rx_mode_left = 0;
   logic [15:0] rx_mask = '1;
   int      rx_phase = 0;
   bit      rx_bit;

   tanh_soft_clip_distortion_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .req_channel_in  (req_channel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_channel_out (rsp_channel_out),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint unsigned exp_decay_q30(longint unsigned y);
      longint unsigned n, f, term, r;
      longint          acc;
      n = y >> POST_FRAC;
      f = y & (longint'(ONE_Q30) - 1);
      term = ONE_Q30;
      acc = longint'(ONE_Q30);
      if (n > EXP_MAX_INT) return 0;
      for (int i = 1; i <= EXP_TERMS; i++) begin
         term = ((term * f) >> POST_FRAC) / longint'(i);
         if (i % 2) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      r = longint'(acc);
      while (n > 0) begin
         r = (r * INV_E_Q30 + (longint'(ONE_Q30) >> 1)) >> POST_FRAC;
         n--;
      end
      return r;
   endfunction

   function automatic void build_tanh_knees();
      longint unsigned e, num, den;
      for (int k = 0; k <= TANH_SEGMENTS_DEF; k++) begin
         e = exp_decay_q30((longint'(k) << 34) / TANH_SEGMENTS_DEF);
         if (e > ONE_Q30) e = ONE_Q30;
         num = longint'(ONE_Q30) - e;
         den = longint'(ONE_Q30) + e;
         tanh_knee[k] = ((num << (SB - 1)) + den / 2) / den;
         if (k > 0 && tanh_knee[k] < tanh_knee[k-1]) tanh_knee[k] = tanh_knee[k-1];
      end
   endfunction

   function automatic longint gain_from_centi_db(int centi);
      int d;
      d = centi;
      if (d < -int'(POST_MAG_MAX)) d = -int'(POST_MAG_MAX);
      if (d > 0) d = 0;
      return longint'(exp_decay_q30(longint'(-d) * LN10_CENTI_DB_Q30));
   endfunction

   function automatic longint round_half_up(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint shape_wet(longint u);
      int              fb = SB - 1 + DRIVE_FRAC;
      longint unsigned mag, pos, idx, w, t;
      mag = (u < 0) ? longint'(-u) : longint'(u);
      if (mag >= (64'd8 << fb)) begin
         t = 64'd1 << (SB - 1);
      end else begin
         pos = mag * TANH_SEGMENTS_DEF;
         idx = pos >> (fb + 3);
         w = (pos & ((64'd1 << (fb + 3)) - 1)) >> (fb + 3 - WEIGHT_W);
         if (idx >= TANH_SEGMENTS_DEF) idx = TANH_SEGMENTS_DEF - 1;
         t = tanh_knee[idx] + (((tanh_knee[idx+1] - tanh_knee[idx]) * w) >> WEIGHT_W);
      end
      return (u < 0) ? -longint'(t) : longint'(t);
   endfunction

   function automatic logic signed [SB-1:0] distort_sample(logic signed [SB-1:0] x_in);
      longint x, m, u, wet, sum, s, v, hi, lo;
      x = longint'(x_in);
      m = (mix_now > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_now);
      u = x * longint'(drive_now);
      wet = shape_wet(u);
      sum = wet * m + x * (longint'(MIX_ONE) - m);
      s = round_half_up(sum, MIX_FRAC);
      v = round_half_up(s * post_scale_now, POST_FRAC);
      hi = (longint'(1) << (SB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[SB-1:0];
   endfunction

   function automatic logic signed [SB-1:0] random_sample();
      logic signed [SB-1:0] s;
      case ($urandom_range(0, 5))
         0: s = SB'(int'($urandom_range(0, 4000)) - 2000);
         1: begin
            s = {1'b0, {(SB-1){1'b1}}} - SB'($urandom_range(0, 4095));
            if ($urandom_range(0, 1)) s = ~s;
         end
         default: s = SB'($urandom);
      endcase
      return s;
   endfunction

   task automatic send(logic signed [SB-1:0] s, logic ch);
      samples_to_send.push_back('{s, ch});
   endtask

   task automatic wait_drained();
      wait (samples_to_send.size() == 0 && outputs_due.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic signed [POST_DB_W-1:0] centi;
      centi = data[POST_DB_W-1:0];
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DRIVE_GAIN: drive_now = 32'(data);
         CSR_WET_MIX:    mix_now = 32'(data);
         CSR_POST_GAIN:  post_scale_now = gain_from_centi_db(int'(centi));
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [15:0] d, logic [15:0] m, logic [15:0] p);
      wait_drained();
      write_register(CSR_DRIVE_GAIN, d);
      write_register(CSR_WET_MIX, m);
      write_register(CSR_POST_GAIN, p);
   endtask

   // accept requests and record the outputs they should produce
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         outputs_due.push_back('{distort_sample(req_sample_in), req_channel_in});
         void'(samples_to_send.pop_front());
         requests_accepted++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
         // hold the offered request
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
         req_valid <= 1'b1;
         req_sample_in <= samples_to_send[0].sample;
         req_channel_in <= samples_to_send[0].channel;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 4);
         end
      end else begin
         req_valid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(16, 160);
         rx_mask = 16'($urandom);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_ALWAYS: rx_bit = 1'b1;
         RX_COIN:   rx_bit = 1'($urandom_range(0, 1));
         default: begin
            rx_bit = rx_mask[rx_phase % 16];
            rx_phase++;
         end
      endcase
      rsp_ready <= rx_bit && !hold_off;
   end

   // hold off the response side long enough to back up the pipeline
   initial begin
      wait (requests_accepted >= 150);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outputs_due.size() == 0) begin
            if (errors < 10)
               $display("unexpected response: sample %0d channel %0d",
                        rsp_sample_out, rsp_channel_out);
            errors++;
         end else if (rsp_sample_out !== outputs_due[0].sample ||
                      rsp_channel_out !== outputs_due[0].channel) begin
            if (errors < 10)
               $display("mismatch: expected sample %0d channel %0d, got sample %0d channel %0d",
                        outputs_due[0].sample, outputs_due[0].channel,
                        rsp_sample_out, rsp_channel_out);
            errors++;
            void'(outputs_due.pop_front());
         end else begin
            void'(outputs_due.pop_front());
         end
      end
   end

   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] d, m, p;
      int          n;
      build_tanh_knees();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(24'sh7FFFFF, 1'b0);
      send(-24'sh800000, 1'b1);
      send(24'sd0, 1'b0);
      send(24'sd1, 1'b1);
      send(-24'sd1, 1'b0);
      send(24'sh400000, 1'b1);
      send(-24'sh400000, 1'b0);

      apply_settings(16'd40960, MIX_ONE, 16'(-1200));
      send(24'sd6710887, 1'b1);
      send(-24'sd6710887, 1'b0);
      send(24'sd6710886, 1'b1);
      send(24'sh7FFFFF, 1'b0);
      send(-24'sh800000, 1'b1);

      apply_settings(16'd0, 16'hFFFF, 16'd100);
      write_register(CSR_UNUSED, 16'hA5A5);
      send(24'sh7FFFFF, 1'b1);
      send(-24'sh800000, 1'b0);
      send(24'sd12345, 1'b1);

      apply_settings(16'hFFFF, 16'd0, 16'h0800);
      send(24'sh7FFFFF, 1'b0);
      send(-24'sh800000, 1'b1);
      send(-24'sd1, 1'b0);

      apply_settings(DRIVE_RESET, 16'd16384, 16'(-600));
      send(24'sh7FFFFF, 1'b1);
      send(-24'sh800000, 1'b0);
      send(24'sd3000000, 1'b1);
      send(-24'sd3000000, 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 7))
            0:       d = 16'd0;
            1:       d = 16'hFFFF;
            2:       d = 16'($urandom);
            default: d = 16'($urandom_range(4096, 40960));
         endcase
         case ($urandom_range(0, 7))
            0:       m = 16'd0;
            1:       m = MIX_ONE;
            2:       m = 16'($urandom);
            default: m = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 7))
            0:       p = 16'd0;
            1:       p = 16'(-1200);
            2:       p = 16'($urandom);
            default: p = 16'(-int'($urandom_range(0, 1200)));
         endcase
         apply_settings(d, m, p);
         n = $urandom_range(220, 250);
         repeat (n) send(random_sample(), 1'($urandom_range(0, 1)));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && outputs_due.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* sim.f */
hdl/tscd_pkg.sv
hdl/tscd_post_gain.sv
hdl/tscd_shaper.sv
hdl/tscd_mix.sv
hdl/tanh_soft_clip_distortion_top.sv
tb/sv/testbench.sv
